>>> sv/aicc_pkg.sv
// Package: command codes, payload structs and fixed constants for the credit controller.
`timescale 1ns / 1ps

package aicc_pkg;

    localparam int CreditWidth = 7;

    typedef enum logic [7:0] {
        CMD_NOP      = 8'h10,
        CMD_POLL     = 8'h71,
        CMD_SWITCH   = 8'ha1,
        CMD_CLEAR    = 8'hb1,
        CMD_CREDIT_A = 8'hc1,
        CMD_DIPS     = 8'hd2,
        CMD_CREDIT_B = 8'he1
    } aicc_cmd_t;

    localparam logic [1:0] BYTES_NONE = 2'd0;
    localparam logic [1:0] BYTES_DIPS = 2'd2;
    localparam logic [1:0] BYTES_FULL = 2'd3;

    localparam logic [7:0] SWITCH_MODE_REPLY = 8'h80;
    localparam logic [7:0] POLL_TAIL         = 8'hff;

    typedef struct packed {
        logic [7:0] cmd;
        logic       coin_pressed;
        logic       start_one_pressed;
        logic       start_two_pressed;
        logic [7:0] control_port;
        logic [7:0] dip_a;
        logic [7:0] dip_b;
    } aicc_in_t;

    typedef struct packed {
        logic [1:0] bytes_written;
        logic [7:0] reply_first;
        logic [7:0] reply_second;
        logic [7:0] reply_third;
        logic       unknown_command;
    } aicc_out_t;

endpackage

>>> sv/aicc_in_stage.sv
// Input register stage: captures one command transaction and holds it for the core.
`timescale 1ns / 1ps

module aicc_in_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  aicc_pkg::aicc_in_t s_data,
    output logic             q_valid,
    input  logic             q_ready,
    output aicc_pkg::aicc_in_t q_data
);
    import aicc_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    aicc_in_t data_reg;

    assign s_ready = !valid_reg || q_ready;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            data_reg <= s_data;
        end
    end

    assign q_valid = valid_reg;
    assign q_data  = data_reg;

endmodule

>>> sv/aicc_core.sv
// Command decode, credit counter, edge memories and the result register.
`timescale 1ns / 1ps

module aicc_core #(
    parameter int MAX_CREDITS = 99
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  aicc_pkg::aicc_in_t in_data,
    output logic               m_valid,
    input  logic               m_ready,
    output aicc_pkg::aicc_out_t m_data
);
    import aicc_pkg::*;

    localparam logic [CreditWidth-1:0] MaxCredit = CreditWidth'(MAX_CREDITS);

    logic [CreditWidth-1:0] credit_reg, credit_next;
    logic                   switch_mode_reg, switch_mode_next;
    logic                   coin_held_reg, coin_held_next;
    logic                   start_one_held_reg, start_one_held_next;
    logic                   start_two_held_reg, start_two_held_next;
    logic                   fire_held_reg, fire_held_next;
    logic                   valid_reg, valid_next;
    aicc_out_t              result_reg, result_next;

    logic                   take;
    logic [CreditWidth-1:0] after_coin, after_one, after_two;
    logic                   fire_pressed;
    logic [7:0]             shaped;
    logic [3:0]             dir_code;
    logic [14:0]            tens_prod;
    logic [3:0]             tens;
    logic [3:0]             ones;
    logic [7:0]             bcd;

    assign in_ready = !valid_reg || m_ready;
    assign take     = in_valid && in_ready;

    // credit arithmetic in poll order: coin, start one, start two
    always_comb begin
        after_coin = credit_reg;
        if (in_data.coin_pressed && !coin_held_reg && credit_reg < MaxCredit) begin
            after_coin = credit_reg + CreditWidth'(1);
        end
        after_one = after_coin;
        if (in_data.start_one_pressed && !start_one_held_reg &&
            after_coin >= CreditWidth'(1)) begin
            after_one = after_coin - CreditWidth'(1);
        end
        after_two = after_one;
        if (in_data.start_two_pressed && !start_two_held_reg &&
            after_one >= CreditWidth'(2)) begin
            after_two = after_one - CreditWidth'(2);
        end
    end

    // tens = floor(n * 205 / 2048), exact for n below 180
    assign tens_prod = {8'd0, after_two} * 15'd205;
    assign tens      = tens_prod[14:11];
    assign ones      = 4'(after_two - CreditWidth'(tens) * CreditWidth'(10));
    assign bcd       = {tens, ones};

    always_comb begin
        fire_pressed = !in_data.control_port[5];
        shaped       = in_data.control_port;
        if (fire_pressed && !fire_held_reg) begin
            shaped[4] = 1'b0;
        end
        if (!shaped[0]) begin
            dir_code = 4'd0;
        end else if (!shaped[1]) begin
            dir_code = 4'd2;
        end else if (!shaped[2]) begin
            dir_code = 4'd4;
        end else if (!shaped[3]) begin
            dir_code = 4'd6;
        end else begin
            dir_code = 4'd8;
        end
        shaped[3:0] = dir_code;
    end

    always_comb begin
        credit_next         = credit_reg;
        switch_mode_next    = switch_mode_reg;
        coin_held_next      = coin_held_reg;
        start_one_held_next = start_one_held_reg;
        start_two_held_next = start_two_held_reg;
        fire_held_next      = fire_held_reg;
        valid_next          = valid_reg;
        result_next         = result_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
        if (take) begin
            result_next = '0;
            unique case (in_data.cmd) inside
                CMD_NOP: begin
                end
                CMD_POLL: begin
                    credit_next                = after_two;
                    coin_held_next             = in_data.coin_pressed;
                    start_one_held_next        = in_data.start_one_pressed;
                    start_two_held_next        = in_data.start_two_pressed;
                    fire_held_next             = fire_pressed;
                    result_next.bytes_written  = BYTES_FULL;
                    result_next.reply_first    = switch_mode_reg ? SWITCH_MODE_REPLY : bcd;
                    result_next.reply_second   = shaped;
                    result_next.reply_third    = POLL_TAIL;
                end
                CMD_CLEAR: begin
                    credit_next               = '0;
                    result_next.bytes_written = BYTES_FULL;
                end
                CMD_SWITCH: begin
                    switch_mode_next = 1'b1;
                end
                CMD_CREDIT_A, CMD_CREDIT_B: begin
                    switch_mode_next = 1'b0;
                end
                CMD_DIPS: begin
                    result_next.bytes_written = BYTES_DIPS;
                    result_next.reply_first   = in_data.dip_a;
                    result_next.reply_second  = in_data.dip_b;
                end
                default: begin
                    result_next.unknown_command = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            credit_reg         <= '0;
            switch_mode_reg    <= 1'b0;
            coin_held_reg      <= 1'b0;
            start_one_held_reg <= 1'b0;
            start_two_held_reg <= 1'b0;
            fire_held_reg      <= 1'b0;
            valid_reg          <= 1'b0;
        end else begin
            credit_reg         <= credit_next;
            switch_mode_reg    <= switch_mode_next;
            coin_held_reg      <= coin_held_next;
            start_one_held_reg <= start_one_held_next;
            start_two_held_reg <= start_two_held_next;
            fire_held_reg      <= fire_held_next;
            valid_reg          <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

    assign m_valid = valid_reg;
    assign m_data  = result_reg;

endmodule

>>> sv/arcade_io_credit_controller.sv
// Top level of the command-driven input controller with coin credit counter.
// Usage:
//   s_valid/s_ready/s_data carry one command transaction: the command byte
//   together with the coin, start and control levels and both DIP banks.
//   m_valid/m_ready/m_data return exactly one result transaction per command:
//   byte count, three reply bytes and an unknown-command flag.
// Path: an accepted command passes the input register, then the result register,
//   before it is presented on m_data.
// Throughput: one command per cycle while m_ready is high; the decode and credit
//   update between the two registers are combinational.
// Reset (aresetn low, synchronous): credits zero, credit mode, all edge
//   memories cleared, both stages empty.
// Stall: while m_ready is low the result holds; an empty input register still
//   takes one more command, after which s_ready drops until m_ready returns.
// MAX_CREDITS sets the coin ceiling (2 to 99).
`timescale 1ns / 1ps

module arcade_io_credit_controller #(
    parameter int MAX_CREDITS = 99
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  aicc_pkg::aicc_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output aicc_pkg::aicc_out_t m_data
);
    import aicc_pkg::*;

    logic     q_valid;
    logic     q_ready;
    aicc_in_t q_data;

    aicc_in_stage u_in_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data)
    );

    aicc_core #(
        .MAX_CREDITS (MAX_CREDITS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_data  (q_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
